[hdl/char_class_token_scanner_macros.svh]
// Assertion macros shared by the character class token scanner.
`ifndef CHAR_CLASS_TOKEN_SCANNER_MACROS_SVH
`define CHAR_CLASS_TOKEN_SCANNER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CCTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccts check failed");

// Antecedent implies consequent in the next cycle.
`define CCTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccts check failed");

`endif

[hdl/ccts_pkg.sv]
// Types and constants of the character class token scanner.
package ccts_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_APPEND   = 3'd1,
    KIND_DROP     = 3'd2,
    KIND_END_KEEP = 3'd3,
    KIND_END_TAKE = 3'd4,
    KIND_EOS      = 3'd5
  } kind_e;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;

  localparam logic [2:0] MODE_SCAN_OVER = 3'd0;
  localparam logic [2:0] MODE_SCAN_TO   = 3'd1;
  localparam logic [2:0] MODE_SKIP_OVER = 3'd2;
  localparam logic [2:0] MODE_SKIP_TO   = 3'd3;
  localparam logic [2:0] MODE_NEXT_CHAR = 3'd4;
  localparam logic [2:0] MODE_QUOTED    = 3'd5;

  localparam logic CFG_CLASS_MASK = 1'b0;
  localparam logic CFG_SCAN_MODE  = 1'b1;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

endpackage

[hdl/char_class_token_scanner.sv]
// Character class token scanner: each input item passes through stage 1 and the output
// register to its result item. Throughput is one item per cycle while the output is not
// stalled; the class table read is registered in the RAM, and stage 1 updates the scan state.
// Reset clears the scan state, the valid and configuration registers and one valid
// bit per table entry at once; an entry not yet written counts as no class. No clearing
// pass is needed. s_axis_tready depends on m_axis_tready when stage 1 is full.
module char_class_token_scanner #(
  parameter int CLASS_COUNT = 32,
  parameter int CODE_COUNT  = 128,
  parameter int MAX_TOKEN   = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // char_code [7:0], class_bits [39:8]
  input  logic [1:0]  s_axis_tuser,  // op [1:0]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // char_out [7:0], token_length [LenW+7:8], token_overflow [LenW+8]
  output logic [((9+$clog2(MAX_TOKEN+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // kind [2:0]
  output logic        m_axis_tlast   // scan_done
);

  import ccts_pkg::*;

  localparam int TblW   = (CLASS_COUNT < 32) ? CLASS_COUNT : 32;
  localparam int AddrW  = $clog2(CODE_COUNT);
  localparam int LenW   = $clog2(MAX_TOKEN + 1);
  localparam int OutW   = ((9 + LenW + 7) / 8) * 8;
  localparam int PackW  = 9 + LenW;

  // Configuration registers.
  logic [31:0] class_mask_q;
  logic [2:0]  scan_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_mask_q <= '0;
      scan_mode_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLASS_MASK: class_mask_q <= cfg_data_i;
        CFG_SCAN_MODE:  scan_mode_q  <= cfg_data_i[2:0];
        default:        ;
      endcase
    end
  end

  // Input unpacking and handshake.
  logic [7:0]       in_char;
  logic [1:0]       in_op;
  logic             in_acc;
  logic             in_range;
  logic [AddrW-1:0] in_addr;
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             s1_adv;

  assign in_char  = s_axis_tdata[7:0];
  assign in_op    = s_axis_tuser;
  assign in_range = {1'b0, in_char} < 9'(CODE_COUNT);
  assign in_addr  = in_char[AddrW-1:0];

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Class table: written at acceptance, read at acceptance, data used in stage 1.
  logic            tbl_we;
  logic [TblW-1:0] tbl_rdata;
  logic [CODE_COUNT-1:0] entry_valid_q;

  assign tbl_we = in_acc && (in_op == OP_WRITE) && in_range;

  ccts_ram #(
    .Width(TblW),
    .Depth(CODE_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(in_addr),
    .wdata_i(s_axis_tdata[8 +: TblW]),
    .re_i   (in_acc),
    .raddr_i(in_addr),
    .rdata_o(tbl_rdata)
  );

  // Stage 1 registers.
  logic [1:0] s1_op_q;
  logic [7:0] s1_char_q;
  logic       s1_hit_q;  // entry in range and written

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      entry_valid_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (tbl_we) begin
        entry_valid_q[in_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= in_op;
      s1_char_q <= in_char;
      s1_hit_q  <= in_range && entry_valid_q[in_addr];
    end
  end

  // Scan state.
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      quote_q, quote_d;
  logic            quote_known_q, quote_known_d;
  logic            esc_q, esc_d;

  logic  member;
  kind_e kind;
  logic  done;
  logic [LenW-1:0] len_rep;
  logic            ovf_rep;
  logic [7:0]      char_rep;

  assign member = s1_hit_q && |(tbl_rdata & class_mask_q[TblW-1:0]);

  always_comb begin
    quote_d       = quote_q;
    quote_known_d = quote_known_q;
    esc_d         = esc_q;
    kind          = KIND_EOS;
    char_rep      = s1_char_q;
    case (s1_op_q)
      OP_WRITE: kind = KIND_WRITE;
      OP_CHAR: begin
        case (scan_mode_q)
          MODE_SCAN_OVER: kind = member ? KIND_APPEND : KIND_END_KEEP;
          MODE_SCAN_TO:   kind = member ? KIND_END_KEEP : KIND_APPEND;
          MODE_SKIP_OVER: kind = member ? KIND_DROP : KIND_END_KEEP;
          MODE_SKIP_TO:   kind = member ? KIND_END_KEEP : KIND_DROP;
          MODE_NEXT_CHAR: kind = member ? KIND_END_TAKE : KIND_END_KEEP;
          MODE_QUOTED: begin
            if (!quote_known_q) begin
              quote_d       = s1_char_q;
              quote_known_d = 1'b1;
              kind          = KIND_DROP;
            end else if (esc_q) begin
              esc_d = 1'b0;
              kind  = KIND_APPEND;
            end else if (s1_char_q == quote_q) begin
              kind = KIND_END_TAKE;
            end else if (s1_char_q == CHAR_NEWLINE) begin
              kind = KIND_END_KEEP;
            end else if (s1_char_q == CHAR_BACKSLASH) begin
              esc_d = 1'b1;
              kind  = KIND_DROP;
            end else begin
              kind = KIND_APPEND;
            end
          end
          default: kind = KIND_END_KEEP;
        endcase
      end
      default: begin
        kind     = KIND_EOS;
        char_rep = '0;
      end
    endcase

    done = (kind == KIND_END_KEEP) || (kind == KIND_END_TAKE) || (kind == KIND_EOS);

    len_rep = len_q;
    ovf_rep = ovf_q;
    if (kind == KIND_APPEND) begin
      if (len_q < LenW'(MAX_TOKEN)) begin
        len_rep = len_q + 1'b1;
      end else begin
        ovf_rep = 1'b1;
      end
    end

    // The result reports the final figures; the next scan starts clean.
    len_d = len_rep;
    ovf_d = ovf_rep;
    if (done) begin
      len_d         = '0;
      ovf_d         = 1'b0;
      quote_d       = '0;
      quote_known_d = 1'b0;
      esc_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q         <= '0;
      ovf_q         <= 1'b0;
      quote_q       <= '0;
      quote_known_q <= 1'b0;
      esc_q         <= 1'b0;
    end else if (s1_adv) begin
      len_q         <= len_d;
      ovf_q         <= ovf_d;
      quote_q       <= quote_d;
      quote_known_q <= quote_known_d;
      esc_q         <= esc_d;
    end
  end

  // Output register.
  logic [PackW-1:0] out_pack_q;
  kind_e            out_kind_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pack_q <= {ovf_rep, len_rep, char_rep};
      out_kind_q <= kind;
      out_last_q <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_pack_q);
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // Checks.
  `include "char_class_token_scanner_macros.svh"

  `CCTS_ASSERT_IMP(a_last_matches_kind, m_axis_tvalid, m_axis_tlast == (m_axis_tuser >= KIND_END_KEEP))
  `CCTS_ASSERT_IMP(a_len_bounded, 1'b1, len_q <= LenW'(MAX_TOKEN))
  `CCTS_ASSERT_IMP(a_ovf_at_limit, ovf_q, len_q == LenW'(MAX_TOKEN))
  `CCTS_ASSERT_NXT(a_stage_holds, s1_valid_q && out_valid_q && !m_axis_tready, s1_valid_q)

endmodule

[hdl/ccts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ccts_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sim/char_class_token_scanner_checker.sv]
// Checker for the character class token scanner: predicts each result item and compares it.
module char_class_token_scanner_checker #(
  parameter int CLASS_COUNT = 32,
  parameter int CODE_COUNT  = 128,
  parameter int MAX_TOKEN   = 4096,
  parameter int LEN_W       = $clog2(MAX_TOKEN + 1),
  parameter int OUT_W       = ((9 + LEN_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [39:0]      s_tdata_i,  // char_code [7:0], class_bits [39:8]
  input  logic [1:0]       s_tuser_i,  // op [1:0]
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [OUT_W-1:0] m_tdata_i,  // char_out, token_length, token_overflow
  input  logic [2:0]       m_tuser_i,  // kind [2:0]
  input  logic             m_tlast_i,  // scan_done
  output int               pending_o,
  output int               fail_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ccts_pkg::*;

  localparam logic [31:0] CLASS_LIMIT =
      (CLASS_COUNT >= 32) ? 32'hFFFF_FFFF : ((32'd1 << CLASS_COUNT) - 32'd1);

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       ch;
    logic             done;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } token_result_t;

  logic [31:0] class_tab [CODE_COUNT];
  logic [31:0] class_mask;
  logic [2:0]  scan_mode;
  logic [7:0]  quote_char;
  logic        quote_known;
  logic        escape_pending;
  int          token_len;
  logic        token_ovf;

  token_result_t token_results_q[$];

  function automatic void clear_token();
    token_len      = 0;
    token_ovf      = 1'b0;
    quote_known    = 1'b0;
    quote_char     = 8'h00;
    escape_pending = 1'b0;
  endfunction

  function automatic token_result_t scan_char(logic [1:0] op, logic [7:0] code,
                                              logic [31:0] bits);
    token_result_t r;
    logic hit;
    r.ch   = code;
    r.done = 1'b0;
    if (op == OP_WRITE) begin
      if (code < CODE_COUNT) class_tab[code] = bits;
      r.kind = KIND_WRITE;
    end else if (op == OP_CHAR) begin
      hit = (code < CODE_COUNT) && ((class_tab[code] & class_mask & CLASS_LIMIT) != 0);
      case (scan_mode)
        MODE_SCAN_OVER: r.kind = hit ? KIND_APPEND : KIND_END_KEEP;
        MODE_SCAN_TO:   r.kind = hit ? KIND_END_KEEP : KIND_APPEND;
        MODE_SKIP_OVER: r.kind = hit ? KIND_DROP : KIND_END_KEEP;
        MODE_SKIP_TO:   r.kind = hit ? KIND_END_KEEP : KIND_DROP;
        MODE_NEXT_CHAR: r.kind = hit ? KIND_END_TAKE : KIND_END_KEEP;
        MODE_QUOTED: begin
          // Tested in order escape, closing quote, backslash, so a backslash quote closes.
          if (!quote_known) begin
            quote_char  = code;
            quote_known = 1'b1;
            r.kind      = KIND_DROP;
          end else if (escape_pending) begin
            escape_pending = 1'b0;
            r.kind         = KIND_APPEND;
          end else if (code == quote_char) begin
            r.kind = KIND_END_TAKE;
          end else if (code == CHAR_NEWLINE) begin
            r.kind = KIND_END_KEEP;
          end else if (code == CHAR_BACKSLASH) begin
            escape_pending = 1'b1;
            r.kind         = KIND_DROP;
          end else begin
            r.kind = KIND_APPEND;
          end
        end
        default: r.kind = KIND_END_KEEP;
      endcase
      if (r.kind == KIND_APPEND) begin
        if (token_len < MAX_TOKEN) token_len++;
        else token_ovf = 1'b1;
      end
      r.done = (r.kind == KIND_END_KEEP) || (r.kind == KIND_END_TAKE);
    end else begin
      r.kind = KIND_EOS;
      r.ch   = 8'h00;
      r.done = 1'b1;
    end
    r.len = token_len[LEN_W-1:0];
    r.ovf = token_ovf;
    if (r.done) clear_token();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    token_result_t want;
    token_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < CODE_COUNT; i++) class_tab[i] = 32'h0;
      class_mask = 32'h0;
      scan_mode  = MODE_SCAN_OVER;
      clear_token();
      token_results_q.delete();
      fail_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CLASS_MASK) class_mask = cfg_data_i;
        else scan_mode = cfg_data_i[2:0];
      end
      // Retire the output first so an item accepted at this edge cannot cover a stray result.
      if (m_tvalid_i && m_tready_i) begin
        got.kind = kind_e'(m_tuser_i);
        got.ch   = m_tdata_i[7:0];
        got.len  = m_tdata_i[LEN_W+7:8];
        got.ovf  = m_tdata_i[LEN_W+8];
        got.done = m_tlast_i;
        if (token_results_q.size() == 0) begin
          fail_o++;
          $display("%0t: unexpected result: actual kind %0d char %02h done %0b len %0d ovf %0b",
                   $realtime, got.kind, got.ch, got.done, got.len, got.ovf);
        end else begin
          want = token_results_q.pop_front();
          if (got !== want) begin
            fail_o++;
            $display({"%0t: result mismatch: expected kind %0d char %02h done %0b len %0d",
                      " ovf %0b, actual kind %0d char %02h done %0b len %0d ovf %0b"},
                     $realtime, want.kind, want.ch, want.done, want.len, want.ovf,
                     got.kind, got.ch, got.done, got.len, got.ovf);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        token_results_q.push_back(scan_char(s_tuser_i, s_tdata_i[7:0], s_tdata_i[39:8]));
    end
    pending_o = token_results_q.size();
  end

endmodule

[sim/char_class_token_scanner_tb.sv]
// Testbench top of the character class token scanner: stimulus, idling and verdict.
module char_class_token_scanner_tb;
  import ccts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TOKEN  = 4096;
  localparam int LEN_W      = $clog2(MAX_TOKEN + 1);
  localparam int OUT_W      = ((9 + LEN_W + 7) / 8) * 8;
  localparam int RAND_ITEMS = 1100;
  localparam int STALL_LIMIT = 4000;

  localparam logic [1:0] OP_EOS   = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [31:0] cfg_data = 32'h0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = 40'h0;
  logic [1:0]  s_user = 2'b00;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;
  logic [2:0]       m_user;
  logic             m_last;

  int pending;
  int fail_count;
  int src_idle_pct = 7;
  int sink_idle_pct = 70;
  int items_pushed = 0;
  int stall_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  char_class_token_scanner #(.MAX_TOKEN(MAX_TOKEN)) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  char_class_token_scanner_checker #(.MAX_TOKEN(MAX_TOKEN)) i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_valid),
    .s_tready_i (s_ready),
    .s_tdata_i  (s_data),
    .s_tuser_i  (s_user),
    .m_tvalid_i (m_valid),
    .m_tready_i (m_ready),
    .m_tdata_i  (m_data),
    .m_tuser_i  (m_user),
    .m_tlast_i  (m_last),
    .pending_o  (pending),
    .fail_o     (fail_count)
  );

  always @(posedge clk) begin
    m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Valid stays high from one item to the next unless the sender decides to idle.
  task automatic push_item(input logic [1:0] op, input logic [7:0] code,
                           input logic [31:0] bits);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {bits, code};
    do @(posedge clk); while (s_ready !== 1'b1);
    items_pushed++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] mask, input logic [2:0] mode);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CLASS_MASK;
    cfg_data <= mask;
    @(posedge clk);
    cfg_idx  <= CFG_SCAN_MODE;
    cfg_data <= ($urandom() & 32'hFFFF_FFF8) | {29'h0, mode};
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      0:       return CHAR_BACKSLASH;
      1:       return CHAR_NEWLINE;
      2:       return CHAR_DQUOTE;
      3:       return CHAR_SQUOTE;
      4:       return 8'($urandom_range(128, 255));
      5:       return 8'($urandom_range(0, 255));
      default: return CHAR_A + 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [31:0] pick_class_bits();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_noise_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) push_item(OP_WRITE, pick_char(), pick_class_bits());
    else if (r < 93) push_item(OP_CHAR, pick_char(), $urandom());
    else push_item($urandom_range(0, 1) ? OP_EOS : OP_SPARE, 8'($urandom()), $urandom());
  endtask

  // A quote, a body with some escapes, then mostly the closing quote.
  task automatic send_quoted_string();
    logic [7:0] quote;
    int r;
    int body;
    r = $urandom_range(0, 9);
    quote = (r < 5) ? CHAR_DQUOTE : (r < 8) ? CHAR_SQUOTE : (r < 9) ? CHAR_BACKSLASH
          : pick_char();
    push_item(OP_CHAR, quote, $urandom());
    body = $urandom_range(0, 12);
    repeat (body) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        push_item(OP_CHAR, CHAR_BACKSLASH, $urandom());
        push_item(OP_CHAR, pick_char(), $urandom());
      end else if (r < 3) begin
        push_item(OP_CHAR, pick_char(), $urandom());
      end else if (r < 4) begin
        push_item(OP_WRITE, pick_char(), pick_class_bits());
      end else begin
        push_item(OP_CHAR, CHAR_LOW_A + 8'($urandom_range(0, 25)), $urandom());
      end
    end
    r = $urandom_range(0, 9);
    if (r < 6) push_item(OP_CHAR, quote, $urandom());
    else if (r < 8) push_item(OP_CHAR, CHAR_NEWLINE, $urandom());
    else if (r < 9) push_item(OP_EOS, 8'($urandom()), $urandom());
  endtask

  initial begin
    int seg;
    int seg_len;
    int base;
    int rand_base;
    logic [2:0]  mode;
    logic [31:0] mask;

    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed part on the reset table.
    set_config(32'h0, MODE_SCAN_OVER);
    push_item(OP_CHAR, CHAR_A, $urandom());
    push_item(OP_WRITE, CHAR_A, 32'hFFFF_FFFF);
    push_item(OP_WRITE, 8'd127, 32'h8000_0001);
    push_item(OP_WRITE, 8'd128, 32'hFFFF_FFFF);
    push_item(OP_WRITE, 8'd255, 32'hFFFF_FFFF);
    push_item(OP_WRITE, 8'd0, 32'h0000_0001);
    drain_results();
    set_config(32'hFFFF_FFFF, MODE_SCAN_OVER);
    push_item(OP_CHAR, CHAR_A, $urandom());
    push_item(OP_CHAR, 8'd0, $urandom());
    push_item(OP_CHAR, 8'd127, $urandom());
    push_item(OP_CHAR, 8'd255, $urandom());
    drain_results();
    set_config(32'h8000_0000, MODE_NEXT_CHAR);
    push_item(OP_CHAR, 8'd127, $urandom());
    push_item(OP_CHAR, 8'd0, $urandom());
    drain_results();
    set_config(32'hFFFF_FFFF, MODE_QUOTED);
    push_item(OP_CHAR, CHAR_DQUOTE, $urandom());
    push_item(OP_CHAR, CHAR_LOW_A, $urandom());
    push_item(OP_CHAR, CHAR_BACKSLASH, $urandom());
    push_item(OP_CHAR, CHAR_DQUOTE, $urandom());
    push_item(OP_CHAR, CHAR_BACKSLASH, $urandom());
    push_item(OP_CHAR, CHAR_NEWLINE, $urandom());
    push_item(OP_WRITE, CHAR_LOW_A, $urandom());
    push_item(OP_CHAR, CHAR_DQUOTE, $urandom());
    push_item(OP_CHAR, CHAR_BACKSLASH, $urandom());
    push_item(OP_CHAR, CHAR_LOW_A, $urandom());
    push_item(OP_CHAR, CHAR_BACKSLASH, $urandom());
    push_item(OP_CHAR, CHAR_SQUOTE, $urandom());
    push_item(OP_CHAR, CHAR_NEWLINE, $urandom());
    push_item(OP_EOS, 8'hFF, $urandom());
    push_item(OP_SPARE, 8'h00, $urandom());

    // Random part in segments, each with its own register setting.
    rand_base = items_pushed;
    seg = 0;
    while (items_pushed - rand_base < RAND_ITEMS) begin
      drain_results();
      if (items_pushed - rand_base >= (2 * RAND_ITEMS) / 3) begin
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
      end else if (items_pushed - rand_base >= RAND_ITEMS / 3) begin
        src_idle_pct  <= 70;
        sink_idle_pct <= 7;
      end
      if (seg < 8) mode = seg[2:0];
      else if ($urandom_range(0, 9) < 8) mode = 3'($urandom_range(0, 5));
      else mode = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
      case (seg % 5)
        0:       mask = 32'hFFFF_FFFF;
        1:       mask = 32'h0;
        2:       mask = 32'h1 << $urandom_range(0, 31);
        3:       mask = $urandom();
        default: mask = $urandom() & $urandom();
      endcase
      set_config(mask, mode);
      seg_len = $urandom_range(20, 50);
      base = items_pushed;
      while (items_pushed - base < seg_len) begin
        if (mode == MODE_QUOTED && $urandom_range(0, 3) != 0) send_quoted_string();
        else send_noise_item();
      end
      seg++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/ccts_pkg.sv
hdl/ccts_ram.sv
hdl/char_class_token_scanner.sv
sim/char_class_token_scanner_checker.sv
sim/char_class_token_scanner_tb.sv
